@@ hw/rtl/dma_physical_run_iterator_core_assert.svh @@
// Assertion macros for the physical run iterator, empty in synthesis.
`ifndef DMA_PHYSICAL_RUN_ITERATOR_CORE_ASSERT_SVH
`define DMA_PHYSICAL_RUN_ITERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DPRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run iterator check failed");
`define DPRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run iterator sequencing check failed");
`else
`define DPRC_ASSERT_IMP(lbl, ante, cons)
`define DPRC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/dprc_pkg.sv @@
// Shared constants, codes and widths of the physical run iterator.
`timescale 1ns / 1ps
package dprc_pkg;
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int MAX_PAGES_DEF    = 256;
    localparam int MAX_SEGMENTS_DEF = 64;

    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 21;
    localparam int SEGST_W = 20;
    localparam int POFF_W  = 12;
    localparam int PCNT_W  = 9;
    localparam int SCNT_W  = 7;
    localparam int IDX_W   = 8;
    localparam int ACT_W   = 2;
    localparam int CFGI_W  = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_PAGE = 2'd0,
        ACT_LOAD_SEG  = 2'd1,
        ACT_RESTART   = 2'd2,
        ACT_NEXT_RUN  = 2'd3
    } action_t;

    localparam logic [CFGI_W-1:0] CFG_PAGE_OFFSET = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_BUF_LENGTH  = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_PAGE_COUNT  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_SEG_COUNT   = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_RUN_LIMIT   = 3'd4;
endpackage

@@ hw/rtl/dma_physical_run_iterator_core.sv @@
// Top level of the physical run iterator: registers, walk sequencer and tables.
`timescale 1ns / 1ps
`include "dma_physical_run_iterator_core_assert.svh"
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------------
//  command   | start / busy              | action, entry_index, page_address, segment_*
//  result    | result_valid (one cycle)  | run_address, run_length, done_res
//  config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A load beat writes its table entry and leaves the block idle. A restart
// opens the first segment. A next-run beat merges pages into the run and skips
// empty segments: each page step waits on the registered read of the page
// table, which is the one port through which the walk proceeds.
// Reset clears the control, configuration and walk registers but not the run
// and result payload registers or the tables, which hold nothing meaningful
// until loaded. The result cannot be stalled: it is shown for exactly one
// cycle, and busy is already low in that cycle.
module dma_physical_run_iterator_core #(
    parameter int PAGE_BYTES   = dprc_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES    = dprc_pkg::MAX_PAGES_DEF,
    parameter int MAX_SEGMENTS = dprc_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dprc_pkg::ACT_W-1:0]   action,
    input  logic [dprc_pkg::IDX_W-1:0]   entry_index,
    input  logic [dprc_pkg::ADDR_W-1:0]  page_address,
    input  logic [dprc_pkg::SEGST_W-1:0] segment_start,
    input  logic [dprc_pkg::LEN_W-1:0]   segment_bytes,
    output logic                         result_valid,
    output logic [dprc_pkg::ADDR_W-1:0]  run_address,
    output logic [dprc_pkg::LEN_W-1:0]   run_length,
    output logic                         done_res,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dprc_pkg::CFGI_W-1:0]  cfg_index,
    input  logic [31:0]                  cfg_data
);
    import dprc_pkg::*;

    // Page size is a power of two, so page arithmetic is shifting and masking.
    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int PI_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SA_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int PC_W  = $clog2(MAX_PAGES + 1);
    localparam int CP_W  = ((LEN_W - PG_SH) > PC_W) ? (LEN_W - PG_SH) : PC_W;

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_OPEN      = 10'b00_0000_0010,
        ST_SEG_LD    = 10'b00_0000_0100,
        ST_PAGE_CALC = 10'b00_0000_1000,
        ST_CHECK     = 10'b00_0001_0000,
        ST_FIRST     = 10'b00_0010_0000,
        ST_PART_CHK  = 10'b00_0100_0000,
        ST_LOOP      = 10'b00_1000_0000,
        ST_LOOP_CHK  = 10'b01_0000_0000,
        ST_FINISH    = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [POFF_W-1:0] pg_off_reg;
    logic [LEN_W-1:0]  buf_len_reg;
    logic [PCNT_W-1:0] page_cnt_reg;
    logic [SCNT_W-1:0] seg_cnt_reg;
    logic [LEN_W-1:0]  run_limit_reg;

    // Walk state, kept from one beat to the next.
    logic [SCNT_W-1:0]  next_seg_reg, next_seg_next;
    logic [SEGST_W-1:0] seg_start_reg, seg_start_next;
    logic [LEN_W-1:0]   seg_len_reg, seg_len_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   walked_reg, walked_next;
    logic [CP_W-1:0]    cur_page_reg, cur_page_next;
    logic [PI_W-1:0]    final_page_reg, final_page_next;
    logic               restart_reg, restart_next;

    // Working values of the run being built.
    logic [ADDR_W-1:0] phys_reg, phys_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  ret_reg, ret_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;

    // Result registers.
    logic              res_valid_reg, res_valid_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;

    // Table ports.
    logic              accept;
    logic              page_we;
    logic              seg_we;
    logic [PI_W-1:0]   page_raddr;
    logic [ADDR_W-1:0] page_rd;
    logic [SEGST_W-1:0] seg_rd_start;
    logic [LEN_W-1:0]  seg_rd_len;

    // Derived live values.
    logic [PC_W-1:0]   live_pc;
    logic [SCNT_W-1:0] live_sc;
    logic              pc_is_one;
    logic              unlimited;
    logic [POFF_W-1:0] in_page_off;
    logic [LEN_W-1:0]  seg_base;
    logic [PG_SH-1:0]  align;
    logic [21:0]       span;
    logic [21:0]       last_raw;
    logic [CP_W-1:0]   cp_inc;
    logic              cp_past_final;
    logic [LEN_W-1:0]  first_len;
    logic [LEN_W-1:0]  inc;
    logic [LEN_W-1:0]  fin_len;
    logic              open_fails;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign page_we = accept && (action_t'(action) == ACT_LOAD_PAGE)
                     && ({24'd0, entry_index} < 32'(MAX_PAGES));
    assign seg_we  = accept && (action_t'(action) == ACT_LOAD_SEG)
                     && ({24'd0, entry_index} < 32'(MAX_SEGMENTS));

    assign live_pc   = ({23'd0, page_cnt_reg} > 32'(MAX_PAGES)) ? PC_W'(MAX_PAGES)
                                                                : PC_W'(page_cnt_reg);
    assign live_sc   = ({25'd0, seg_cnt_reg} > 32'(MAX_SEGMENTS)) ? SCNT_W'(MAX_SEGMENTS)
                                                                  : seg_cnt_reg;
    assign pc_is_one = (live_pc == PC_W'(1));
    assign unlimited = (run_limit_reg == '0);

    // The buffer's offset within its page, and the segment's base from there.
    assign in_page_off = pg_off_reg & POFF_W'(PAGE_BYTES - 1);
    assign seg_base    = LEN_W'(in_page_off) + LEN_W'(seg_start_reg);
    assign align       = seg_base[PG_SH-1:0];

    // Last page that the segment touches, before clamping to the table.
    assign span     = 22'(seg_len_reg) + 22'(seg_base) - 22'd1;
    assign last_raw = span >> PG_SH;

    assign cp_inc        = cur_page_reg + CP_W'(1);
    assign cp_past_final = (32'(cp_inc) > 32'(final_page_reg));

    assign first_len = ((LEN_W'(PAGE_BYTES) - LEN_W'(align)) > remain_reg)
                       ? remain_reg : (LEN_W'(PAGE_BYTES) - LEN_W'(align));
    assign inc       = (remain_reg < LEN_W'(PAGE_BYTES)) ? remain_reg : LEN_W'(PAGE_BYTES);
    // Length cut to the run limit, applied as the walk leaves the merge loop.
    assign fin_len   = (!unlimited && (ret_reg > run_limit_reg)) ? run_limit_reg : ret_reg;

    assign open_fails = (seg_cnt_reg != '0) ? (next_seg_reg >= live_sc)
                        : ((buf_len_reg == '0) || (walked_reg == buf_len_reg));

    // The page read address follows the page that the walk moves to.
    assign page_raddr = PI_W'(cur_page_next);

    always_comb
    begin
        state_next      = state_reg;
        next_seg_next   = next_seg_reg;
        seg_start_next  = seg_start_reg;
        seg_len_next    = seg_len_reg;
        pos_next        = pos_reg;
        walked_next     = walked_reg;
        cur_page_next   = cur_page_reg;
        final_page_next = final_page_reg;
        restart_next    = restart_reg;
        phys_next       = phys_reg;
        addr_next       = addr_reg;
        ret_next        = ret_reg;
        remain_next     = remain_reg;
        res_valid_next  = 1'b0;
        res_addr_next   = res_addr_reg;
        res_len_next    = res_len_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(action))
                        ACT_RESTART:
                        begin
                            next_seg_next   = '0;
                            seg_start_next  = '0;
                            seg_len_next    = '0;
                            pos_next        = '0;
                            walked_next     = '0;
                            cur_page_next   = '0;
                            final_page_next = '0;
                            restart_next    = 1'b1;
                            state_next      = ST_OPEN;
                        end
                        ACT_NEXT_RUN:
                        begin
                            restart_next = 1'b0;
                            state_next   = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_OPEN:
            begin
                if (open_fails)
                begin
                    // On a next-run beat a failed open ends the walk with the zero-length run.
                    ret_next   = '0;
                    state_next = restart_reg ? ST_IDLE : ST_FINISH;
                end
                else if (seg_cnt_reg != '0)
                begin
                    state_next = ST_SEG_LD;
                end
                else
                begin
                    seg_len_next   = buf_len_reg;
                    seg_start_next = '0;
                    pos_next       = '0;
                    state_next     = ST_PAGE_CALC;
                end
            end

            ST_SEG_LD:
            begin
                seg_len_next   = seg_rd_len;
                seg_start_next = seg_rd_start;
                next_seg_next  = next_seg_reg + SCNT_W'(1);
                pos_next       = '0;
                state_next     = ST_PAGE_CALC;
            end

            ST_PAGE_CALC:
            begin
                cur_page_next = pc_is_one ? '0 : CP_W'(seg_base >> PG_SH);
                if ((seg_len_reg != '0) && (live_pc != '0))
                begin
                    if (last_raw > 22'(live_pc - PC_W'(1)))
                    begin
                        final_page_next = PI_W'(live_pc - PC_W'(1));
                    end
                    else
                    begin
                        final_page_next = PI_W'(last_raw);
                    end
                end
                else
                begin
                    final_page_next = '0;
                end
                state_next = restart_reg ? ST_IDLE : ST_CHECK;
            end

            ST_CHECK:
            begin
                if (pos_reg >= seg_len_reg)
                begin
                    state_next = ST_OPEN;
                end
                else if (32'(cur_page_reg) >= 32'(live_pc))
                begin
                    ret_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    remain_next = seg_len_reg - pos_reg;
                    ret_next    = '0;
                    state_next  = ST_FIRST;
                end
            end

            ST_FIRST:
            begin
                if (pc_is_one)
                begin
                    // A single page entry maps the whole buffer contiguously.
                    addr_next = page_rd + ADDR_W'(pos_reg) + ADDR_W'(seg_base);
                    ret_next  = remain_reg;
                    if (!unlimited && (remain_reg > run_limit_reg))
                    begin
                        ret_next = (run_limit_reg > LEN_W'(align))
                                   ? (run_limit_reg - LEN_W'(align)) : '0;
                    end
                    state_next = ST_FINISH;
                end
                else if ((pos_reg == '0) && (align != '0))
                begin
                    // Partial first page. A run that ends here is not cut to
                    // the run limit.
                    addr_next     = page_rd + ADDR_W'(align);
                    ret_next      = first_len;
                    remain_next   = remain_reg - first_len;
                    cur_page_next = cp_inc;
                    phys_next     = page_rd;
                    state_next    = cp_past_final ? ST_FINISH : ST_PART_CHK;
                end
                else
                begin
                    addr_next  = page_rd;
                    phys_next  = page_rd;
                    state_next = ST_LOOP;
                end
            end

            ST_PART_CHK, ST_LOOP_CHK:
            begin
                if ((phys_reg + ADDR_W'(PAGE_BYTES)) != page_rd)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    phys_next  = page_rd;
                    state_next = ST_LOOP;
                end
            end

            ST_LOOP:
            begin
                if ((remain_reg != '0) && (32'(cur_page_reg) <= 32'(final_page_reg)))
                begin
                    if (!unlimited && ((22'(ret_reg) + 22'(inc)) > 22'(run_limit_reg)))
                    begin
                        ret_next   = fin_len;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ret_next      = ret_reg + inc;
                        remain_next   = remain_reg - inc;
                        cur_page_next = cp_inc;
                        state_next    = cp_past_final ? ST_FINISH : ST_LOOP_CHK;
                    end
                end
                else
                begin
                    ret_next   = fin_len;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                walked_next    = walked_reg + ret_reg;
                pos_next       = pos_reg + ret_reg;
                res_valid_next = 1'b1;
                res_len_next   = ret_reg;
                res_addr_next  = (ret_reg != '0) ? addr_reg : '0;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pg_off_reg     <= '0;
            buf_len_reg    <= '0;
            page_cnt_reg   <= '0;
            seg_cnt_reg    <= '0;
            run_limit_reg  <= '0;
            next_seg_reg   <= '0;
            seg_start_reg  <= '0;
            seg_len_reg    <= '0;
            pos_reg        <= '0;
            walked_reg     <= '0;
            cur_page_reg   <= '0;
            final_page_reg <= '0;
            restart_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_seg_reg   <= next_seg_next;
            seg_start_reg  <= seg_start_next;
            seg_len_reg    <= seg_len_next;
            pos_reg        <= pos_next;
            walked_reg     <= walked_next;
            cur_page_reg   <= cur_page_next;
            final_page_reg <= final_page_next;
            restart_reg    <= restart_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PAGE_OFFSET: pg_off_reg    <= cfg_data[POFF_W-1:0];
                    CFG_BUF_LENGTH:  buf_len_reg   <= cfg_data[LEN_W-1:0];
                    CFG_PAGE_COUNT:  page_cnt_reg  <= cfg_data[PCNT_W-1:0];
                    CFG_SEG_COUNT:   seg_cnt_reg   <= cfg_data[SCNT_W-1:0];
                    CFG_RUN_LIMIT:   run_limit_reg <= cfg_data[LEN_W-1:0];
                    default:
                    begin
                        run_limit_reg <= run_limit_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers of the run and of the result.
    always_ff @(posedge clk)
    begin
        phys_reg     <= phys_next;
        addr_reg     <= addr_next;
        ret_reg      <= ret_next;
        remain_reg   <= remain_next;
        res_addr_reg <= res_addr_next;
        res_len_reg  <= res_len_next;
    end

    assign result_valid = res_valid_reg;
    assign run_address  = res_addr_reg;
    assign run_length   = res_len_reg;
    assign done_res     = (res_len_reg == '0);

    dprc_page_ram #(
        .DEPTH (MAX_PAGES),
        .AW    (PI_W)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (PI_W'(entry_index)),
        .wdata (page_address),
        .raddr (page_raddr),
        .rdata (page_rd)
    );

    dprc_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (SA_W)
    ) u_seg_ram (
        .clk    (clk),
        .we     (seg_we),
        .waddr  (SA_W'(entry_index)),
        .wstart (segment_start),
        .wlen   (segment_bytes),
        .raddr  (SA_W'(next_seg_reg)),
        .rstart (seg_rd_start),
        .rlen   (seg_rd_len)
    );

    // A result is only ever shown once the sequencer is back at rest.
    `DPRC_ASSERT_IMP(a_res_idle, result_valid, !busy)
    // A zero-length run carries a zero address.
    `DPRC_ASSERT_IMP(a_res_zero_addr, result_valid && (run_length == '0), run_address == '0)
    // A next-run beat always keeps the block busy in the following cycle.
    `DPRC_ASSERT_NXT(a_next_busy, start && !busy && (action == ACT_NEXT_RUN), busy)
    // In the check state the clamped last page of the segment lies within the table.
    `DPRC_ASSERT_IMP(a_final_in_table, (live_pc != '0) && (state_reg == ST_CHECK),
                     32'(final_page_reg) < 32'(live_pc))
endmodule

@@ hw/rtl/dprc_page_ram.sv @@
// Page address table: one write port, one registered read port.
`timescale 1ns / 1ps
module dprc_page_ram #(
    parameter int DEPTH = dprc_pkg::MAX_PAGES_DEF,
    parameter int AW    = 8
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [dprc_pkg::ADDR_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [dprc_pkg::ADDR_W-1:0] rdata
);
    import dprc_pkg::*;

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/dprc_seg_ram.sv @@
// Segment table: start and length of each segment, registered read.
`timescale 1ns / 1ps
module dprc_seg_ram #(
    parameter int DEPTH = dprc_pkg::MAX_SEGMENTS_DEF,
    parameter int AW    = 6
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [dprc_pkg::SEGST_W-1:0] wstart,
    input  logic [dprc_pkg::LEN_W-1:0]   wlen,
    input  logic [AW-1:0]                raddr,
    output logic [dprc_pkg::SEGST_W-1:0] rstart,
    output logic [dprc_pkg::LEN_W-1:0]   rlen
);
    import dprc_pkg::*;

    logic [SEGST_W+LEN_W-1:0] mem [DEPTH];
    logic [SEGST_W+LEN_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wstart, wlen};
        end
        rdata_reg <= mem[raddr];
    end

    assign rstart = rdata_reg[SEGST_W+LEN_W-1:LEN_W];
    assign rlen   = rdata_reg[LEN_W-1:0];
endmodule
